// ===== design/f2p_pkg.sv =====
// Shared types and constants for the float to PCM24 capture block
`default_nettype none
package f2p_pkg;
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_NUM_CHANNELS     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ALL_CHANNELS     = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SELECTED_CHANNEL = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_FRAMES    = 2'd3;

    typedef struct packed {
        logic [31:0] bits;
        logic [5:0]  chan;
        logic        last;
        logic        done;
    } t_item;
endpackage
`default_nettype wire

// ===== design/f2p_front.sv =====
// Front end: channel tracking, selection, frame counting and drop decision
`default_nettype none
module f2p_front #(
    parameter int MAX_CHANNELS     = 64,
    parameter int FRAME_COUNT_BITS = 40
) (
    input  wire  logic                        i_clk,
    input  wire  logic                        i_rst_n,
    input  wire  logic                        i_valid,
    input  wire  logic [31:0]                 i_bits,
    input  wire  logic [6:0]                  i_num_channels,
    input  wire  logic                        i_all_channels,
    input  wire  logic [5:0]                  i_selected_channel,
    input  wire  logic [FRAME_COUNT_BITS-1:0] i_target_frames,
    input  wire  logic                        i_take,
    output       logic                        o_emit,
    output       f2p_pkg::t_item              o_item
);
    localparam int PW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int NW = PW + 2;

    logic [PW-1:0]               r_pos, n_pos;
    logic [FRAME_COUNT_BITS-1:0] r_frames, n_frames;
    logic                        r_done, n_done;
    logic [NW-1:0]               nch, nch_raw, pos_x, sel_x;
    logic                        stop, last, emit;

    always_comb begin
        nch_raw = NW'(i_num_channels);
        nch = nch_raw;
        if (nch_raw == '0) nch = NW'(1);
        if (nch_raw > NW'(MAX_CHANNELS)) nch = NW'(MAX_CHANNELS);
        pos_x = NW'(r_pos);
        sel_x = NW'(i_selected_channel);
        stop = r_done || (r_frames >= i_target_frames);
        last = pos_x >= (nch - NW'(1));
        emit = !stop && (i_all_channels || ((sel_x < nch) && (pos_x == sel_x)));
        n_pos = r_pos;
        n_frames = r_frames;
        n_done = r_done;
        if (i_take) begin
            if (stop) begin
                n_done = 1'b1;
            end else if (last) begin
                n_pos = '0;
                n_frames = r_frames + FRAME_COUNT_BITS'(1);
                if (n_frames >= i_target_frames) n_done = 1'b1;
            end else begin
                n_pos = r_pos + PW'(1);
            end
        end
        o_emit = emit;
        o_item.bits = i_bits;
        o_item.chan = 6'(r_pos);
        o_item.last = i_all_channels ? last : 1'b1;
        o_item.done = n_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_frames <= '0;
            r_done <= 1'b0;
        end else begin
            r_pos <= n_pos;
            r_frames <= n_frames;
            r_done <= n_done;
        end
    end

    logic unused;
    assign unused = i_valid;
endmodule
`default_nettype wire

// ===== design/f2p_queue.sv =====
// Two-entry queue between front and back ends
`default_nettype none
module f2p_queue (
    input  wire  logic           i_clk,
    input  wire  logic           i_rst_n,
    input  wire  logic           i_push,
    input  wire  f2p_pkg::t_item i_item,
    output       logic           o_full,
    output       logic           o_valid,
    output       f2p_pkg::t_item o_item,
    input  wire  logic           i_pop
);
    f2p_pkg::t_item r_mem [2];
    logic           r_wp, r_rp, n_wp, n_rp;
    logic [1:0]     r_cnt, n_cnt;

    always_comb begin
        n_wp = r_wp ^ i_push;
        n_rp = r_rp ^ i_pop;
        n_cnt = r_cnt + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
            r_cnt <= n_cnt;
        end
        if (i_push) r_mem[r_wp] <= i_item;
    end

    assign o_full  = r_cnt[1];
    assign o_valid = r_cnt != 2'd0;
    assign o_item  = r_mem[r_rp];
endmodule
`default_nettype wire

// ===== design/f2p_back.sv =====
// Back end: float clamp, scale by 8388607, round half even to 24 bits
`default_nettype none
module f2p_back (
    input  wire  logic           i_clk,
    input  wire  logic           i_rst_n,
    input  wire  logic           i_valid,
    input  wire  f2p_pkg::t_item i_item,
    output       logic           o_ready,
    output       logic           o_valid,
    input  wire  logic           i_ready,
    output       logic [23:0]    o_pcm,
    output       logic [5:0]     o_chan,
    output       logic           o_last,
    output       logic           o_done
);
    // stage 1: clamp and multiply 24x23 mantissa; stage 2: float round and int round
    logic        r_v1, r_v2;
    logic        r_neg1, r_zero1, r_one1;
    logic [47:0] r_prod;
    logic [7:0]  r_exp1;
    logic [5:0]  r_ch1, r_ch2;
    logic        r_la1, r_dn1, r_la2, r_dn2;
    logic [23:0] r_pcm;

    logic        adv1, adv2;
    logic        s_nan, s_one, s_zero;
    logic [7:0]  e;
    logic [22:0] m;

    assign adv2 = !r_v2 || i_ready;
    assign adv1 = !r_v1 || adv2;
    assign o_ready = adv1;

    always_comb begin
        e = i_item.bits[30:23];
        m = i_item.bits[22:0];
        s_nan = (e == 8'hFF) && (m != '0);
        s_one = (e >= 8'd127) && !s_nan;
        s_zero = s_nan || (e < 8'd103);
    end

    // second stage combinational
    logic [4:0]  sh;
    logic [47:0] pn;
    logic        gb, st, rinc;
    logic [24:0] fm;
    logic [24:0] ipart;
    logic [24:0] whole;
    logic [48:0] fx;
    logic        half, above;
    logic [23:0] mag;
    logic [23:0] pcm;

    always_comb begin
        // value = prod * 2^(exp-150); prod in [2^46-2^23, 2^47)
        pn = r_prod[47] ? r_prod : {r_prod[46:0], 1'b0};
        gb = pn[23];
        st = pn[22:0] != '0;
        rinc = gb && (st || pn[24]);
        fm = 25'(pn[47:24]) + 25'(rinc);
        // fm is a 24/25 bit float mantissa, weight 2^(e2) with e2 = exp-127+ (prod[47]?1:0)
        sh = 5'd0;
        fx = '0;
        if (r_exp1 >= 8'd103) begin
            sh = 5'(8'd126 - r_exp1) + 5'(!r_prod[47]);
            // integer value = fm * 2^(-sh), sh in 0..24
            fx = {fm, 24'd0} >> sh;
        end
        ipart = fx[48:24];
        half  = fx[23] && (fx[22:0] == '0);
        above = fx[23] && !half;
        whole = ipart + 25'(above || (half && ipart[0]));
        mag = whole[23:0];
        if (r_one1) mag = 24'd8388607;
        if (r_zero1) mag = '0;
        pcm = r_neg1 ? (24'd0 - mag) : mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
        end
        if (adv1) begin
            r_neg1  <= i_item.bits[31];
            r_zero1 <= s_zero;
            r_one1  <= s_one;
            r_exp1  <= e;
            r_prod  <= 48'({1'b1, m}) * 48'd8388607;
            r_ch1   <= i_item.chan;
            r_la1   <= i_item.last;
            r_dn1   <= i_item.done;
        end
        if (adv2) begin
            r_pcm <= pcm;
            r_ch2 <= r_ch1;
            r_la2 <= r_la1;
            r_dn2 <= r_dn1;
        end
    end

    assign o_valid = r_v2;
    assign o_pcm   = r_pcm;
    assign o_chan  = r_ch2;
    assign o_last  = r_la2;
    assign o_done  = r_dn2;
endmodule
`default_nettype wire

// ===== design/float_to_pcm24_channel_capture.sv =====
// Top level: float32 to PCM24 channel capture
// Path: input transaction to queue, multiply register, round register, result valid.
// One transaction per cycle while the queue has room; the front end decides and counts.
// A two-entry queue and a stalled output register hold results while input continues.
// Synchronous active-low reset clears channel position, frame count, done flag and
// loads register defaults 2, 1, 0, 48000.
`default_nettype none
module float_to_pcm24_channel_capture #(
    parameter int MAX_CHANNELS     = 64,
    parameter int FRAME_COUNT_BITS = 40
) (
    input  wire  logic        i_clk,
    input  wire  logic        i_rst_n,
    input  wire  logic        i_valid,
    output       logic        o_ready,
    input  wire  logic [31:0] i_sample_bits,
    output       logic        o_valid,
    input  wire  logic        i_ready,
    output       logic signed [23:0] o_pcm_sample,
    output       logic [5:0]  o_channel_number,
    output       logic        o_frame_last,
    output       logic        o_capture_done,
    input  wire  logic        i_cfg_valid,
    output       logic        o_cfg_ready,
    input  wire  logic [1:0]  i_cfg_index,
    input  wire  logic [63:0] i_cfg_data
);
    logic [6:0]                  r_num_channels;
    logic                        r_all_channels;
    logic [5:0]                  r_selected_channel;
    logic [FRAME_COUNT_BITS-1:0] r_target_frames;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_channels <= 7'd2;
            r_all_channels <= 1'b1;
            r_selected_channel <= '0;
            r_target_frames <= FRAME_COUNT_BITS'(48000);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                f2p_pkg::REG_NUM_CHANNELS:     r_num_channels <= i_cfg_data[6:0];
                f2p_pkg::REG_ALL_CHANNELS:     r_all_channels <= i_cfg_data[0];
                f2p_pkg::REG_SELECTED_CHANNEL: r_selected_channel <= i_cfg_data[5:0];
                f2p_pkg::REG_TARGET_FRAMES:
                    r_target_frames <= FRAME_COUNT_BITS'(i_cfg_data[39:0]);
                default: ;
            endcase
        end
    end

    logic           emit, q_full, q_valid, b_ready, take;
    f2p_pkg::t_item f_item, q_item;

    assign o_ready = !q_full;
    assign take = i_valid && !q_full;

    f2p_front #(.MAX_CHANNELS(MAX_CHANNELS), .FRAME_COUNT_BITS(FRAME_COUNT_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_bits(i_sample_bits),
        .i_num_channels(r_num_channels), .i_all_channels(r_all_channels),
        .i_selected_channel(r_selected_channel), .i_target_frames(r_target_frames),
        .i_take(take), .o_emit(emit), .o_item(f_item)
    );

    f2p_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(take && emit), .i_item(f_item),
        .o_full(q_full), .o_valid(q_valid), .o_item(q_item), .i_pop(q_valid && b_ready)
    );

    logic [23:0] pcm;
    f2p_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_item(q_item),
        .o_ready(b_ready), .o_valid(o_valid), .i_ready(i_ready), .o_pcm(pcm),
        .o_chan(o_channel_number), .o_last(o_frame_last), .o_done(o_capture_done)
    );
    assign o_pcm_sample = pcm;
endmodule
`default_nettype wire
